// ----- design/lmfb_pkg.sv -----
// ----------------------------------------------------------------------------
// lmfb_pkg
// shared types and constants of the led matrix frame store
// ----------------------------------------------------------------------------
package lmfb_pkg;

    localparam int ROWS   = 8;
    localparam int COLS   = 8;
    localparam int CELLS  = ROWS * COLS;
    localparam int ADDR_W = (CELLS > 1) ? $clog2(CELLS) : 1;
    localparam int ROW_W  = (ROWS > 1) ? $clog2(ROWS) : 1;
    localparam int COL_W  = (COLS > 1) ? $clog2(COLS) : 1;
    localparam int PIX_W  = 24;

    localparam logic [1:0] OP_CLEAR = 2'd0;
    localparam logic [1:0] OP_MASK  = 2'd1;
    localparam logic [1:0] OP_SCAN  = 2'd2;

    localparam logic [1:0] CFG_FILL_RED   = 2'd0;
    localparam logic [1:0] CFG_FILL_GREEN = 2'd1;
    localparam logic [1:0] CFG_FILL_BLUE  = 2'd2;

    localparam logic [7:0] RST_FILL_RED   = 8'd64;
    localparam logic [7:0] RST_FILL_GREEN = 8'd0;
    localparam logic [7:0] RST_FILL_BLUE  = 8'd64;

    typedef struct packed {
        logic [1:0]  operation;
        logic [31:0] mask_bits;
        logic [3:0]  mask_height;
        logic [3:0]  mask_width;
        logic [2:0]  row_start;
        logic [2:0]  col_start;
    } t_in_item;

    typedef struct packed {
        logic [7:0] out_green;
        logic [7:0] out_red;
        logic [7:0] out_blue;
        logic       last_pixel;
    } t_out_item;

endpackage

// ----- design/lmfb_ram.sv -----
// ----------------------------------------------------------------------------
// lmfb_ram
// generic single write, single read ram with registered read data
// ----------------------------------------------------------------------------
module lmfb_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 64
) (
    input  logic                                     i_clk,
    input  logic                                     i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                         i_wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

// ----- design/led_matrix_framebuffer_blit.sv -----
// ----------------------------------------------------------------------------
// led_matrix_framebuffer_blit
// rgb frame store for an led matrix: clear, glyph stamp and serpentine scan
// ----------------------------------------------------------------------------
// Usage: input words arrive on i_valid/o_ready with an operation code.
// Clear drops the per-pixel flags so every pixel reads black. A glyph
// stamp walks the glyph cells row by row, one cell a cycle, over
// min(height*width, 32) cells, writing the fill colour into the ram
// for each set mask bit inside the matrix. A scan out emits ROWS*COLS
// words on o_valid/i_ready in serpentine order, one word per cycle while
// the receiver takes them; the pace is set by the single ram read port.
// last_pixel marks the final word. The output register lets the next input
// word be accepted while the final word still waits.
// When the receiver stalls, the scan holds its position and re-reads the
// same ram entry, so no word is lost or repeated.
// Fill colours are written through i_cfg_we/i_cfg_idx/i_cfg_data.
// Reset (synchronous, active low) returns to idle, blanks the frame and
// loads the default fill colour; no clearing pass is needed.
// ----------------------------------------------------------------------------
module led_matrix_framebuffer_blit
    import lmfb_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_ready,
    input  t_in_item   i_item,
    output logic       o_valid,
    input  logic       i_ready,
    output t_out_item  o_word,
    input  logic       i_cfg_we,
    input  logic [1:0] i_cfg_idx,
    input  logic [7:0] i_cfg_data
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_STAMP,
        ST_SCAN
    } t_state;

    t_state r_state;

    logic [7:0] r_fill_red;
    logic [7:0] r_fill_green;
    logic [7:0] r_fill_blue;

    logic [CELLS-1:0] r_valid;

    // stamp walk
    logic [31:0] r_mask;
    logic [3:0]  r_h;
    logic [3:0]  r_w;
    logic [2:0]  r_top;
    logic [2:0]  r_left;
    logic [3:0]  r_gr;
    logic [3:0]  r_gc;
    logic [4:0]  r_bit;

    // scan
    logic [ROW_W-1:0] r_row;
    logic [COL_W-1:0] r_k;
    logic             r_rd_ok;
    logic             r_rd_vld;

    logic              in_acc;
    logic [4:0]        mr;
    logic [4:0]        mc;
    logic              st_we;
    logic [ADDR_W-1:0] st_addr;
    logic              st_done;
    logic              sc_last;
    logic              sc_adv;
    logic [ROW_W-1:0]  nxt_row;
    logic [COL_W-1:0]  nxt_k;
    logic [ADDR_W-1:0] rd_addr;
    logic [PIX_W-1:0]  rdata;
    logic [PIX_W-1:0]  pix;

    function automatic logic [ADDR_W-1:0] scan_addr(input logic [ROW_W-1:0] row,
                                                    input logic [COL_W-1:0] k);
        logic [COL_W-1:0] col;
        col = row[0] ? COL_W'(COLS - 1) - k : k;
        return ADDR_W'(ADDR_W'(row) * ADDR_W'(COLS)) + ADDR_W'(col);
    endfunction

    assign o_ready = (r_state == ST_IDLE);
    assign in_acc  = i_valid && o_ready;

    assign mr      = 5'(r_top) + 5'(r_gr);
    assign mc      = 5'(r_left) + 5'(r_gc);
    assign st_we   = (r_state == ST_STAMP) && r_mask[r_bit]
                     && (mr < 5'(ROWS)) && (mc < 5'(COLS));
    assign st_addr = ADDR_W'(ADDR_W'(mr) * ADDR_W'(COLS)) + ADDR_W'(mc);
    assign st_done = ((r_gc == r_w - 4'd1) && (r_gr == r_h - 4'd1)) || (r_bit == 5'd31);

    assign sc_last = (r_row == ROW_W'(ROWS - 1)) && (r_k == COL_W'(COLS - 1));
    assign sc_adv  = (r_state == ST_SCAN) && r_rd_ok && (!o_valid || i_ready);

    always_comb begin
        if (r_k == COL_W'(COLS - 1)) begin
            nxt_k   = '0;
            nxt_row = r_row + ROW_W'(1);
        end else begin
            nxt_k   = r_k + COL_W'(1);
            nxt_row = r_row;
        end
        if (r_state != ST_SCAN) begin
            rd_addr = '0;
        end else if (sc_adv && !sc_last) begin
            rd_addr = scan_addr(nxt_row, nxt_k);
        end else begin
            rd_addr = scan_addr(r_row, r_k);
        end
    end

    lmfb_ram #(
        .WIDTH (PIX_W),
        .DEPTH (CELLS)
    ) u_frame (
        .i_clk   (i_clk),
        .i_we    (st_we),
        .i_waddr (st_addr),
        .i_wdata ({r_fill_red, r_fill_green, r_fill_blue}),
        .i_raddr (rd_addr),
        .o_rdata (rdata)
    );

    assign pix = r_rd_vld ? rdata : '0;

    always_ff @(posedge i_clk) begin
        r_rd_vld <= r_valid[rd_addr];
        if (!i_rst_n) begin
            r_state      <= ST_IDLE;
            r_valid      <= '0;
            r_rd_ok      <= 1'b0;
            o_valid      <= 1'b0;
            r_fill_red   <= RST_FILL_RED;
            r_fill_green <= RST_FILL_GREEN;
            r_fill_blue  <= RST_FILL_BLUE;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_FILL_RED:   r_fill_red   <= i_cfg_data;
                    CFG_FILL_GREEN: r_fill_green <= i_cfg_data;
                    CFG_FILL_BLUE:  r_fill_blue  <= i_cfg_data;
                    default: ;
                endcase
            end

            if (sc_adv) begin
                o_valid           <= 1'b1;
                o_word.out_green  <= pix[15:8];
                o_word.out_red    <= pix[23:16];
                o_word.out_blue   <= pix[7:0];
                o_word.last_pixel <= sc_last;
            end else if (i_ready) begin
                o_valid <= 1'b0;
            end

            if (st_we) begin
                r_valid[st_addr] <= 1'b1;
            end

            case (r_state)
                ST_IDLE: begin
                    if (in_acc) begin
                        case (i_item.operation)
                            OP_CLEAR: r_valid <= '0;
                            OP_MASK: begin
                                r_mask <= i_item.mask_bits;
                                r_h    <= i_item.mask_height;
                                r_w    <= i_item.mask_width;
                                r_top  <= i_item.row_start;
                                r_left <= i_item.col_start;
                                r_gr   <= '0;
                                r_gc   <= '0;
                                r_bit  <= '0;
                                if (i_item.mask_height != 4'd0
                                    && i_item.mask_width != 4'd0) begin
                                    r_state <= ST_STAMP;
                                end
                            end
                            OP_SCAN: begin
                                r_row   <= '0;
                                r_k     <= '0;
                                r_rd_ok <= 1'b1;
                                r_state <= ST_SCAN;
                            end
                            default: ;
                        endcase
                    end
                end
                ST_STAMP: begin
                    r_bit <= r_bit + 5'd1;
                    if (r_gc == r_w - 4'd1) begin
                        r_gc <= '0;
                        r_gr <= r_gr + 4'd1;
                    end else begin
                        r_gc <= r_gc + 4'd1;
                    end
                    if (st_done) begin
                        r_state <= ST_IDLE;
                    end
                end
                ST_SCAN: begin
                    if (sc_adv) begin
                        if (sc_last) begin
                            r_rd_ok <= 1'b0;
                            r_state <= ST_IDLE;
                        end else begin
                            r_row <= nxt_row;
                            r_k   <= nxt_k;
                        end
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    a_rd_only_in_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != ST_SCAN) |-> !r_rd_ok)
        else $error("scan read pending outside scan");

    a_write_only_stamp: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        st_we |-> (r_state == ST_STAMP) && !o_ready)
        else $error("frame write outside glyph stamp");

    a_last_ends_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (sc_adv && sc_last) |=> (r_state == ST_IDLE) && o_valid && o_word.last_pixel)
        else $error("scan did not end on last word");

    a_scan_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && i_item.operation == OP_SCAN) |=> r_rd_ok && (r_row == '0) && (r_k == '0))
        else $error("scan did not start at first pixel");

endmodule
